@@ hw/rtl/fsfe_pkg.sv @@
// Shared types, constants and the flow-key hash for the flow sampling feature extractor.
// Depends on nothing; the files that use it refer to it by scoped names.
package fsfe_pkg;

  localparam int FLOW_ENTRIES = 1024;
  localparam int IDX_W        = $clog2(FLOW_ENTRIES);
  localparam int USED_W       = $clog2(FLOW_ENTRIES) + 1;

  localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [7:0]  PROTO_ICMP    = 8'd1;
  localparam logic [3:0]  IP_VERSION4   = 4'd4;
  localparam logic [16:0] MIN_IP_FRAME  = 17'd34;
  localparam logic [16:0] ETH_HDR_LEN   = 17'd14;
  localparam logic [16:0] TCP_HDR_LEN   = 17'd20;
  localparam logic [16:0] SMALL_L4_LEN  = 17'd8;
  localparam logic [15:0] UDP_HDR_LEN   = 16'd8;
  localparam logic [15:0] SERVICE_PORTS = 16'd1024;
  localparam logic [7:0]  ICMP_ECHO_REQ = 8'd8;
  localparam logic [7:0]  ICMP_ECHO_REP = 8'd0;
  localparam logic [7:0]  LIMIT_RESET   = 8'd100;

  // configuration register indexes
  localparam logic [7:0] CFG_STAMP_OFFSET = 8'd0;
  localparam logic [7:0] CFG_FLOW_LIMIT   = 8'd1;

  typedef struct packed {
    logic [31:0] lo_addr;
    logic [31:0] hi_addr;
    logic [15:0] lo_port;
    logic [15:0] hi_port;
    logic [7:0]  proto;
  } flow_key_t;

  localparam int KEY_W = $bits(flow_key_t);

  typedef struct packed {
    logic        valid;
    flow_key_t   key;
    logic [7:0]  count;
    logic [31:0] server;
  } entry_t;

  typedef struct packed {
    logic [15:0] frame_length;
    logic [15:0] ethertype;
    logic [7:0]  version_ihl;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] l4_head_word;
    logic [7:0]  tcp_flag_byte;
    logic [15:0] tcp_window;
    logic [15:0] udp_length;
    logic [15:0] frag_word;
    logic [63:0] clock_ns;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    flow_key_t   key;
    logic [31:0] server;
    logic [15:0] frag;
    logic [7:0]  tcp_flags;
    logic [15:0] tcp_window;
    logic [7:0]  udp_size;
    logic [7:0]  icmp_type;
  } parse_t;

  // XOR fold of the key down to a table index
  function automatic logic [IDX_W-1:0] key_hash(flow_key_t key);
    logic [IDX_W-1:0] h;
    h = '0;
    for (int i = 0; i < KEY_W; i++) begin
      h[i % IDX_W] = h[i % IDX_W] ^ key[i];
    end
    return h;
  endfunction

endpackage

@@ hw/rtl/fsfe_in_if.sv @@
// Input channel for one frame's header fields: valid/ready plus payload.
// Depends on nothing.
interface fsfe_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_length;
  logic [15:0] ethertype;
  logic [7:0]  version_ihl;
  logic [7:0]  protocol;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [31:0] l4_head_word;
  logic [7:0]  tcp_flag_byte;
  logic [15:0] tcp_window;
  logic [15:0] udp_length;
  logic [15:0] frag_word;
  logic [63:0] clock_ns;

  modport source (output valid, frame_length, ethertype, version_ihl, protocol, src_addr,
                  dst_addr, l4_head_word, tcp_flag_byte, tcp_window, udp_length, frag_word,
                  clock_ns, input ready);
  modport sink (input valid, frame_length, ethertype, version_ihl, protocol, src_addr,
                dst_addr, l4_head_word, tcp_flag_byte, tcp_window, udp_length, frag_word,
                clock_ns, output ready);
endinterface

@@ hw/rtl/fsfe_out_if.sv @@
// Output channel for one feature record: valid/ready plus payload.
// Depends on nothing.
interface fsfe_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] key_low_addr;
  logic [31:0] key_high_addr;
  logic [15:0] key_low_port;
  logic [15:0] key_high_port;
  logic [7:0]  key_protocol;
  logic [63:0] stamp;
  logic [15:0] frag_out;
  logic [7:0]  tcp_flags_out;
  logic [15:0] tcp_window_out;
  logic [7:0]  udp_payload_size;
  logic [7:0]  icmp_type_out;

  modport source (output valid, key_low_addr, key_high_addr, key_low_port, key_high_port,
                  key_protocol, stamp, frag_out, tcp_flags_out, tcp_window_out,
                  udp_payload_size, icmp_type_out, input ready);
  modport sink (input valid, key_low_addr, key_high_addr, key_low_port, key_high_port,
                key_protocol, stamp, frag_out, tcp_flags_out, tcp_window_out,
                udp_payload_size, icmp_type_out, output ready);
endinterface

@@ hw/rtl/flow_sampling_feature_extractor.sv @@
// Flow sampling feature extractor, top level.
// Depends on fsfe_pkg, fsfe_in_if, fsfe_out_if, fsfe_parse and fsfe_table.
//
// Usage:
//   in_if carries one frame's header fields per item; out_if carries one
//   feature record for each frame that is taken. Unqualified frames, frames
//   of a flow at its limit and new flows with the table full give no record.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write the stamp offset (index 0) and
//   per_flow_limit (index 1); other indexes are ignored.
// Timing:
//   A frame passes the accept, key, table read and check steps when its hashed
//   slot hits at once, plus a table read and a check for each further slot probed; the
//   flow table is a hash table with linear probing over a single-port-read
//   memory, and the probe loop sets the rate. Unqualified frames leave after the key step.
//   The record sits in an output register; a new item is accepted while it
//   waits. A stalled receiver holds the next taken frame in the check step.
// Reset:
//   After reset a clearing pass walks all 1024 table entries, one per cycle,
//   during which no item is accepted. Registers return to stamp offset 0 and
//   per_flow_limit 100.
module flow_sampling_feature_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  fsfe_in_if.sink     in_if,
  fsfe_out_if.source  out_if
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_KEY  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;

  localparam logic [fsfe_pkg::IDX_W-1:0]  LAST_IDX  = fsfe_pkg::IDX_W'(fsfe_pkg::FLOW_ENTRIES - 1);
  localparam logic [fsfe_pkg::USED_W-1:0] FULL_USED = fsfe_pkg::USED_W'(fsfe_pkg::FLOW_ENTRIES);

  logic [2:0]                    state_q, state_d;
  logic [fsfe_pkg::IDX_W-1:0]    addr_q, addr_d;
  logic [fsfe_pkg::IDX_W-1:0]    probes_q, probes_d;
  logic [fsfe_pkg::USED_W-1:0]   used_q, used_d;
  logic [63:0]                   epoch_q;
  logic [7:0]                    limit_q;
  fsfe_pkg::in_item_t            item_q;
  fsfe_pkg::parse_t              par;
  fsfe_pkg::parse_t              par_q;
  logic [63:0]                   stamp_q;

  logic                          tbl_we;
  fsfe_pkg::entry_t              tbl_wdata;
  fsfe_pkg::entry_t              tbl_rdata;

  logic                          out_valid_q;
  logic                          emit;
  logic                          out_free;
  logic                          hit;
  logic                          in_acc;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q <= '0;
      limit_q <= fsfe_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == fsfe_pkg::CFG_STAMP_OFFSET) begin
        epoch_q <= cfg_wdata_i;
      end else if (cfg_idx_i == fsfe_pkg::CFG_FLOW_LIMIT) begin
        limit_q <= cfg_wdata_i[7:0];
      end
    end
  end

  assign in_if.ready = (state_q == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;

  // input item register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.frame_length  <= in_if.frame_length;
      item_q.ethertype     <= in_if.ethertype;
      item_q.version_ihl   <= in_if.version_ihl;
      item_q.protocol      <= in_if.protocol;
      item_q.src_addr      <= in_if.src_addr;
      item_q.dst_addr      <= in_if.dst_addr;
      item_q.l4_head_word  <= in_if.l4_head_word;
      item_q.tcp_flag_byte <= in_if.tcp_flag_byte;
      item_q.tcp_window    <= in_if.tcp_window;
      item_q.udp_length    <= in_if.udp_length;
      item_q.frag_word     <= in_if.frag_word;
      item_q.clock_ns      <= in_if.clock_ns;
    end
  end

  fsfe_parse u_parse (
    .item_i (item_q),
    .par_o  (par)
  );

  // parsed item and timestamp
  always_ff @(posedge clk_i) begin
    if (state_q == S_KEY) begin
      par_q   <= par;
      stamp_q <= epoch_q + item_q.clock_ns;
    end
  end

  fsfe_table u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (addr_q),
    .wdata_i (tbl_wdata),
    .raddr_i (addr_q),
    .rdata_o (tbl_rdata)
  );

  assign out_free = !out_valid_q || out_if.ready;
  assign hit      = tbl_rdata.valid && (tbl_rdata.key == par_q.key);

  // lookup, insert and count update
  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    probes_d  = probes_q;
    used_d    = used_q;
    tbl_we    = 1'b0;
    tbl_wdata = '0;
    emit      = 1'b0;
    unique case (state_q)
      S_CLR: begin
        tbl_we = 1'b1;
        addr_d = addr_q + 1'b1;
        if (addr_q == LAST_IDX) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_KEY;
        end
      end
      S_KEY: begin
        addr_d   = fsfe_pkg::key_hash(par.key);
        probes_d = '0;
        state_d  = par.ok ? S_RD : S_IDLE;
      end
      S_RD: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        tbl_wdata.valid  = 1'b1;
        tbl_wdata.key    = par_q.key;
        tbl_wdata.server = tbl_rdata.server;
        tbl_wdata.count  = tbl_rdata.count + 8'd1;
        if (hit) begin
          if (tbl_rdata.count >= limit_q) begin
            state_d = S_IDLE;
          end else if (out_free) begin
            if (tbl_rdata.count == 8'd0) begin
              tbl_wdata.server = par_q.server;
            end
            tbl_we  = 1'b1;
            emit    = 1'b1;
            state_d = S_IDLE;
          end
        end else if (!tbl_rdata.valid) begin
          if (used_q >= FULL_USED) begin
            state_d = S_IDLE;
          end else if (limit_q == 8'd0) begin
            // new flow is tracked but its frame is dropped at once
            tbl_wdata.count  = 8'd0;
            tbl_wdata.server = '0;
            tbl_we  = 1'b1;
            used_d  = used_q + 1'b1;
            state_d = S_IDLE;
          end else if (out_free) begin
            tbl_wdata.count  = 8'd1;
            tbl_wdata.server = par_q.server;
            tbl_we  = 1'b1;
            emit    = 1'b1;
            used_d  = used_q + 1'b1;
            state_d = S_IDLE;
          end
        end else if (probes_q == LAST_IDX) begin
          // every slot holds another flow
          state_d = S_IDLE;
        end else begin
          addr_d   = addr_q + 1'b1;
          probes_d = probes_q + 1'b1;
          state_d  = S_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      addr_q   <= '0;
      probes_q <= '0;
      used_q   <= '0;
    end else begin
      state_q  <= state_d;
      addr_q   <= addr_d;
      probes_q <= probes_d;
      used_q   <= used_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_if.key_low_addr     <= par_q.key.lo_addr;
      out_if.key_high_addr    <= par_q.key.hi_addr;
      out_if.key_low_port     <= par_q.key.lo_port;
      out_if.key_high_port    <= par_q.key.hi_port;
      out_if.key_protocol     <= par_q.key.proto;
      out_if.stamp            <= stamp_q;
      out_if.frag_out         <= par_q.frag;
      out_if.tcp_flags_out    <= par_q.tcp_flags;
      out_if.tcp_window_out   <= par_q.tcp_window;
      out_if.udp_payload_size <= par_q.udp_size;
      out_if.icmp_type_out    <= par_q.icmp_type;
    end
  end

  assign out_if.valid = out_valid_q;

endmodule

@@ hw/rtl/fsfe_parse.sv @@
// Header checks, direction-free key, server guess and per-protocol features.
// Depends on fsfe_pkg.
module fsfe_parse (
  input  fsfe_pkg::in_item_t item_i,
  output fsfe_pkg::parse_t   par_o
);

  logic [16:0] flen;
  logic [16:0] l4_size;
  logic [16:0] l4_end;
  logic        proto_ok;
  logic        is_tcp;
  logic        is_udp;
  logic        is_icmp;
  logic [15:0] sport;
  logic [15:0] dport;
  logic [15:0] sport_num;
  logic [15:0] dport_num;
  logic [7:0]  itype;
  logic [15:0] udp_diff;

  always_comb begin
    is_tcp   = item_i.protocol == fsfe_pkg::PROTO_TCP;
    is_udp   = item_i.protocol == fsfe_pkg::PROTO_UDP;
    is_icmp  = item_i.protocol == fsfe_pkg::PROTO_ICMP;
    proto_ok = is_tcp || is_udp || is_icmp;
    l4_size  = is_tcp ? fsfe_pkg::TCP_HDR_LEN : fsfe_pkg::SMALL_L4_LEN;
    flen     = {1'b0, item_i.frame_length};
    l4_end   = fsfe_pkg::ETH_HDR_LEN + {11'd0, item_i.version_ihl[3:0], 2'b00} + l4_size;

    par_o.ok = (flen >= fsfe_pkg::MIN_IP_FRAME) &&
               (item_i.ethertype == fsfe_pkg::ETYPE_IPV4) &&
               (item_i.version_ihl[7:4] == fsfe_pkg::IP_VERSION4) &&
               proto_ok && (l4_end <= flen);

    itype = item_i.l4_head_word[7:0];
    sport = is_icmp ? 16'd0 : item_i.l4_head_word[15:0];
    dport = is_icmp ? 16'd0 : item_i.l4_head_word[31:16];

    // lower address first; equal addresses put the destination first
    if (item_i.src_addr < item_i.dst_addr) begin
      par_o.key.lo_addr = item_i.src_addr;
      par_o.key.hi_addr = item_i.dst_addr;
      par_o.key.lo_port = sport;
      par_o.key.hi_port = dport;
    end else begin
      par_o.key.lo_addr = item_i.dst_addr;
      par_o.key.hi_addr = item_i.src_addr;
      par_o.key.lo_port = dport;
      par_o.key.hi_port = sport;
    end
    par_o.key.proto = item_i.protocol;

    // server guess, ports compared in numeric (byte-swapped) order
    sport_num = {sport[7:0], sport[15:8]};
    dport_num = {dport[7:0], dport[15:8]};
    priority if (is_tcp && item_i.tcp_flag_byte[1]) begin
      par_o.server = item_i.tcp_flag_byte[4] ? item_i.src_addr : item_i.dst_addr;
    end else if (is_icmp && itype == fsfe_pkg::ICMP_ECHO_REQ) begin
      par_o.server = item_i.dst_addr;
    end else if (is_icmp && itype == fsfe_pkg::ICMP_ECHO_REP) begin
      par_o.server = item_i.src_addr;
    end else if (dport_num < fsfe_pkg::SERVICE_PORTS) begin
      par_o.server = item_i.dst_addr;
    end else if (sport_num < fsfe_pkg::SERVICE_PORTS) begin
      par_o.server = item_i.src_addr;
    end else begin
      par_o.server = (dport_num <= sport_num) ? item_i.dst_addr : item_i.src_addr;
    end

    // feature fields
    udp_diff         = item_i.udp_length - fsfe_pkg::UDP_HDR_LEN;
    par_o.frag       = item_i.frag_word;
    par_o.tcp_flags  = is_tcp ? item_i.tcp_flag_byte : 8'd0;
    par_o.tcp_window = is_tcp ? item_i.tcp_window : 16'd0;
    par_o.udp_size   = is_udp ? udp_diff[7:0] : 8'd0;
    par_o.icmp_type  = is_icmp ? itype : 8'd0;
  end

endmodule

@@ hw/rtl/fsfe_table.sv @@
// Flow table memory: one write port, one read port with registered read data.
// Depends on fsfe_pkg.
module fsfe_table (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [fsfe_pkg::IDX_W-1:0]   waddr_i,
  input  fsfe_pkg::entry_t             wdata_i,
  input  logic [fsfe_pkg::IDX_W-1:0]   raddr_i,
  output fsfe_pkg::entry_t             rdata_o
);

  fsfe_pkg::entry_t mem [fsfe_pkg::FLOW_ENTRIES];
  fsfe_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ tb/tb_flow_sampling_feature_extractor.sv @@
// Self-checking testbench for flow_sampling_feature_extractor.
// Depends on fsfe_pkg, fsfe_in_if and fsfe_out_if. A built-in flow table model
// predicts each feature record, which is compared field by field in order.
module tb_flow_sampling_feature_extractor;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 2500;
  localparam int LONG_HOLD      = 400;
  localparam logic [7:0] CFG_UNUSED = 8'd7;

  typedef struct packed {
    logic [31:0] key_low_addr;
    logic [31:0] key_high_addr;
    logic [15:0] key_low_port;
    logic [15:0] key_high_port;
    logic [7:0]  key_protocol;
    logic [63:0] stamp;
    logic [15:0] frag_out;
    logic [7:0]  tcp_flags_out;
    logic [15:0] tcp_window_out;
    logic [7:0]  udp_payload_size;
    logic [7:0]  icmp_type_out;
  } record_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_idx_i;
  logic [63:0] cfg_wdata_i;

  fsfe_in_if  in_bus ();
  fsfe_out_if out_bus ();

  flow_sampling_feature_extractor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_bus),
    .out_if      (out_bus)
  );

  // model state
  int unsigned          flow_count [logic [fsfe_pkg::KEY_W-1:0]];
  logic [63:0]          stamp_offset;
  logic [7:0]           flow_limit;
  fsfe_pkg::in_item_t   frame_queue [$];
  record_t              record_queue [$];
  int                   errors;
  bit                   no_idle;
  int                   hold_req;
  logic [31:0]          addr_pool [8];
  logic [15:0]          port_pool [8];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // work out the record a frame should produce, updating the flow table
  function automatic bit predict_record(input fsfe_pkg::in_item_t f, output record_t r);
    logic [16:0]         need;
    logic [15:0]         sport;
    logic [15:0]         dport;
    fsfe_pkg::flow_key_t k;
    r = '0;
    if (f.frame_length < 16'd34 || f.ethertype != fsfe_pkg::ETYPE_IPV4) return 0;
    if (f.version_ihl[7:4] != fsfe_pkg::IP_VERSION4) return 0;
    if (f.protocol == fsfe_pkg::PROTO_TCP) need = fsfe_pkg::TCP_HDR_LEN;
    else if (f.protocol == fsfe_pkg::PROTO_UDP || f.protocol == fsfe_pkg::PROTO_ICMP)
      need = fsfe_pkg::SMALL_L4_LEN;
    else return 0;
    need = need + fsfe_pkg::ETH_HDR_LEN + {11'd0, f.version_ihl[3:0], 2'b00};
    if (need > {1'b0, f.frame_length}) return 0;
    sport = f.l4_head_word[15:0];
    dport = f.l4_head_word[31:16];
    if (f.protocol == fsfe_pkg::PROTO_ICMP) begin
      sport = '0;
      dport = '0;
    end
    if (f.src_addr < f.dst_addr) begin
      k = '{f.src_addr, f.dst_addr, sport, dport, f.protocol};
    end else begin
      k = '{f.dst_addr, f.src_addr, dport, sport, f.protocol};
    end
    if (!flow_count.exists(k)) begin
      if (flow_count.num() >= fsfe_pkg::FLOW_ENTRIES) return 0;
      flow_count[k] = 0;
    end
    if (flow_count[k] >= flow_limit) return 0;
    flow_count[k] = flow_count[k] + 1;
    r.key_low_addr     = k.lo_addr;
    r.key_high_addr    = k.hi_addr;
    r.key_low_port     = k.lo_port;
    r.key_high_port    = k.hi_port;
    r.key_protocol     = k.proto;
    r.stamp            = stamp_offset + f.clock_ns;
    r.frag_out         = f.frag_word;
    r.tcp_flags_out    = (f.protocol == fsfe_pkg::PROTO_TCP) ? f.tcp_flag_byte : 8'd0;
    r.tcp_window_out   = (f.protocol == fsfe_pkg::PROTO_TCP) ? f.tcp_window : 16'd0;
    r.udp_payload_size = (f.protocol == fsfe_pkg::PROTO_UDP) ?
                         8'(f.udp_length - fsfe_pkg::UDP_HDR_LEN) : 8'd0;
    r.icmp_type_out    = (f.protocol == fsfe_pkg::PROTO_ICMP) ? f.l4_head_word[7:0] : 8'd0;
    return 1;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // well-formed frame with random content in the unused fields
  function automatic fsfe_pkg::in_item_t build_frame(logic [7:0] proto, logic [31:0] src,
                                                     logic [31:0] dst, logic [15:0] sport,
                                                     logic [15:0] dport, logic [7:0] itype);
    fsfe_pkg::in_item_t f;
    logic [16:0]        min_len;
    f.ethertype     = fsfe_pkg::ETYPE_IPV4;
    f.protocol      = proto;
    f.version_ihl   = {fsfe_pkg::IP_VERSION4, 4'($urandom_range(0, 15))};
    f.src_addr      = src;
    f.dst_addr      = dst;
    f.l4_head_word  = (proto == fsfe_pkg::PROTO_ICMP) ? {dport, sport[15:8], itype} :
                                                        {dport, sport};
    f.tcp_flag_byte = 8'($urandom);
    f.tcp_window    = 16'($urandom);
    f.udp_length    = 16'($urandom);
    f.frag_word     = 16'($urandom);
    f.clock_ns      = {$urandom, $urandom};
    min_len = fsfe_pkg::ETH_HDR_LEN + {11'd0, f.version_ihl[3:0], 2'b00} +
              ((proto == fsfe_pkg::PROTO_TCP) ? fsfe_pkg::TCP_HDR_LEN :
                                                fsfe_pkg::SMALL_L4_LEN);
    if (min_len < fsfe_pkg::MIN_IP_FRAME) min_len = fsfe_pkg::MIN_IP_FRAME;
    if ($urandom_range(0, 99) < 80) f.frame_length = 16'(min_len + $urandom_range(0, 40));
    else f.frame_length = 16'($urandom_range(int'(min_len), 65535));
    return f;
  endfunction

  // random frame over a small set of addresses and ports, with some noise
  function automatic fsfe_pkg::in_item_t rand_frame(int addr_span, int port_span);
    fsfe_pkg::in_item_t f;
    logic [7:0]         proto;
    logic [7:0]         itype;
    int                 r;
    r = $urandom_range(0, 99);
    proto = (r < 40) ? fsfe_pkg::PROTO_TCP : (r < 75) ? fsfe_pkg::PROTO_UDP :
                                                        fsfe_pkg::PROTO_ICMP;
    r = $urandom_range(0, 2);
    itype = (r == 0) ? fsfe_pkg::ICMP_ECHO_REP : (r == 1) ? fsfe_pkg::ICMP_ECHO_REQ :
                                                            8'($urandom);
    f = build_frame(proto, addr_pool[$urandom_range(0, addr_span - 1)],
                    addr_pool[$urandom_range(0, addr_span - 1)],
                    port_pool[$urandom_range(0, port_span - 1)],
                    port_pool[$urandom_range(0, port_span - 1)], itype);
    if ($urandom_range(0, 99) < 12) begin
      case ($urandom_range(0, 4))
        0: f.ethertype = 16'($urandom);
        1: f.version_ihl = 8'($urandom);
        2: f.protocol = 8'($urandom);
        3: f.frame_length = 16'($urandom_range(0, 80));
        default: f = fsfe_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom,
                                           $urandom, $urandom, $urandom, $urandom});
      endcase
    end
    return f;
  endfunction

  task automatic write_cfg(logic [7:0] idx, logic [63:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == fsfe_pkg::CFG_STAMP_OFFSET) stamp_offset = data;
    else if (idx == fsfe_pkg::CFG_FLOW_LIMIT) flow_limit = data[7:0];
  endtask

  // wait until the block is idle and every record has come
  task automatic drain();
    while (frame_queue.size() != 0 || in_bus.valid || record_queue.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_random(int count, int addr_span, int port_span);
    repeat (count) frame_queue.push_back(rand_frame(addr_span, port_span));
  endtask

  task automatic push_directed();
    fsfe_pkg::in_item_t f;
    logic [31:0]        a;
    logic [31:0]        b;
    a = 32'h0100_000a;
    b = 32'h0200_000a;
    // TCP SYN at exact minimum length, then SYN+ACK the other way
    f = build_frame(fsfe_pkg::PROTO_TCP, a, b, 16'h3930, 16'h5000, 8'd0);
    f.version_ihl = 8'h45; f.frame_length = 16'd54; f.tcp_flag_byte = 8'h02;
    frame_queue.push_back(f);
    f = build_frame(fsfe_pkg::PROTO_TCP, b, a, 16'h5000, 16'h3930, 8'd0);
    f.tcp_flag_byte = 8'h12;
    frame_queue.push_back(f);
    // one byte short of the TCP header
    f.version_ihl = 8'h45; f.frame_length = 16'd53;
    frame_queue.push_back(f);
    // UDP with service ports on both sides, length field wrapping
    f = build_frame(fsfe_pkg::PROTO_UDP, a, b, 16'h3500, 16'h3500, 8'd0);
    f.udp_length = 16'd0;
    frame_queue.push_back(f);
    f = build_frame(fsfe_pkg::PROTO_UDP, b, a, 16'hffff, 16'h0004, 8'd0);
    f.udp_length = 16'd8;
    frame_queue.push_back(f);
    // ICMP echo request, echo reply, other type
    frame_queue.push_back(build_frame(fsfe_pkg::PROTO_ICMP, a, b, 16'h1234, 16'h5678,
                                      fsfe_pkg::ICMP_ECHO_REQ));
    frame_queue.push_back(build_frame(fsfe_pkg::PROTO_ICMP, b, a, 16'h1234, 16'h5678,
                                      fsfe_pkg::ICMP_ECHO_REP));
    frame_queue.push_back(build_frame(fsfe_pkg::PROTO_ICMP, a, b, 16'h0, 16'h0, 8'd3));
    // equal addresses, and both addresses zero
    frame_queue.push_back(build_frame(fsfe_pkg::PROTO_TCP, a, a, 16'h0100, 16'h0200, 8'd0));
    frame_queue.push_back(build_frame(fsfe_pkg::PROTO_TCP, 32'd0, 32'd0, 16'h0, 16'h0, 8'd0));
    // unqualified frames
    f = build_frame(fsfe_pkg::PROTO_TCP, a, b, 16'h1, 16'h2, 8'd0);
    f.ethertype = 16'h86dd;
    frame_queue.push_back(f);
    f = build_frame(fsfe_pkg::PROTO_TCP, a, b, 16'h1, 16'h2, 8'd0);
    f.version_ihl = 8'h65;
    frame_queue.push_back(f);
    f = build_frame(fsfe_pkg::PROTO_TCP, a, b, 16'h1, 16'h2, 8'd0);
    f.protocol = 8'd47;
    frame_queue.push_back(f);
    f.protocol = fsfe_pkg::PROTO_UDP; f.frame_length = 16'd33;
    frame_queue.push_back(f);
    f.frame_length = 16'd0;
    frame_queue.push_back(f);
    // all-ones fields with the longest frame and widest IP header
    f = build_frame(fsfe_pkg::PROTO_TCP, 32'hffff_ffff, 32'hffff_fffe, 16'hffff, 16'hffff,
                    8'd0);
    f.version_ihl = 8'h4f; f.frame_length = 16'hffff; f.tcp_flag_byte = 8'hff;
    f.tcp_window = 16'hffff; f.frag_word = 16'hffff; f.clock_ns = '1;
    frame_queue.push_back(f);
    // UDP with the widest IP header at exact length, then one byte short
    f = build_frame(fsfe_pkg::PROTO_UDP, b, 32'hffff_ffff, 16'h0008, 16'h0009, 8'd0);
    f.version_ihl = 8'h4f; f.frame_length = 16'd82; f.udp_length = 16'hffff;
    frame_queue.push_back(f);
    f.frame_length = 16'd81;
    frame_queue.push_back(f);
    // zero clock
    f = build_frame(fsfe_pkg::PROTO_UDP, 32'd0, 32'hffff_ffff, 16'h0, 16'h0, 8'd0);
    f.clock_ns = '0; f.frag_word = '0;
    frame_queue.push_back(f);
  endtask

  // sender: offers queued frames and predicts on acceptance
  fsfe_pkg::in_item_t cur_frame;
  bit                 offering;
  int                 send_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    record_t rec;
    if (!rst_ni) begin
      offering = 1'b0;
      send_gap = 0;
      cur_frame = '0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        if (predict_record(cur_frame, rec)) record_queue.push_back(rec);
        offering = 1'b0;
        send_gap = pick_gap();
      end
      if (!offering) begin
        if (send_gap > 0) send_gap--;
        else if (frame_queue.size() != 0) begin
          cur_frame = frame_queue.pop_front();
          offering = 1'b1;
        end
      end
    end
    in_bus.valid         <= offering;
    in_bus.frame_length  <= cur_frame.frame_length;
    in_bus.ethertype     <= cur_frame.ethertype;
    in_bus.version_ihl   <= cur_frame.version_ihl;
    in_bus.protocol      <= cur_frame.protocol;
    in_bus.src_addr      <= cur_frame.src_addr;
    in_bus.dst_addr      <= cur_frame.dst_addr;
    in_bus.l4_head_word  <= cur_frame.l4_head_word;
    in_bus.tcp_flag_byte <= cur_frame.tcp_flag_byte;
    in_bus.tcp_window    <= cur_frame.tcp_window;
    in_bus.udp_length    <= cur_frame.udp_length;
    in_bus.frag_word     <= cur_frame.frag_word;
    in_bus.clock_ns      <= cur_frame.clock_ns;
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // receiver: compares records and throttles ready
  int hold_seen;
  int hold_left;
  int recv_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    record_t want;
    bit      rdy;
    if (!rst_ni) begin
      hold_seen = 0;
      hold_left = 0;
      recv_gap = 0;
      rdy = 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (record_queue.size() == 0) begin
          $error("record with none expected");
          errors++;
        end else begin
          want = record_queue.pop_front();
          check_field("key_low_addr", want.key_low_addr, out_bus.key_low_addr);
          check_field("key_high_addr", want.key_high_addr, out_bus.key_high_addr);
          check_field("key_low_port", want.key_low_port, out_bus.key_low_port);
          check_field("key_high_port", want.key_high_port, out_bus.key_high_port);
          check_field("key_protocol", want.key_protocol, out_bus.key_protocol);
          check_field("stamp", want.stamp, out_bus.stamp);
          check_field("frag_out", want.frag_out, out_bus.frag_out);
          check_field("tcp_flags_out", want.tcp_flags_out, out_bus.tcp_flags_out);
          check_field("tcp_window_out", want.tcp_window_out, out_bus.tcp_window_out);
          check_field("udp_payload_size", want.udp_payload_size, out_bus.udp_payload_size);
          check_field("icmp_type_out", want.icmp_type_out, out_bus.icmp_type_out);
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        recv_gap = pick_gap();
      end
    end
    out_bus.ready <= rdy;
  end

  // watchdog on cycles without any handshake
  int idle_cycles;
  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int need;
    errors = 0;
    no_idle = 1'b0;
    hold_req = 0;
    idle_cycles = 0;
    stamp_offset = '0;
    flow_limit = fsfe_pkg::LIMIT_RESET;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;
    addr_pool[0] = 32'd0;
    addr_pool[1] = 32'hffff_ffff;
    port_pool[0] = 16'd0;
    port_pool[1] = 16'hffff;
    port_pool[2] = 16'h5000;
    port_pool[3] = 16'hbb01;
    for (int i = 2; i < 8; i++) addr_pool[i] = $urandom;
    for (int i = 4; i < 8; i++) port_pool[i] = 16'($urandom);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed frames, extreme offset, widest limit
    write_cfg(CFG_UNUSED, {$urandom, $urandom});
    write_cfg(fsfe_pkg::CFG_STAMP_OFFSET, '1);
    write_cfg(fsfe_pkg::CFG_FLOW_LIMIT, 64'd255);
    push_directed();
    drain();

    // tight flow set with a small limit; receiver stalls while sender streams
    write_cfg(fsfe_pkg::CFG_STAMP_OFFSET, {$urandom, $urandom});
    write_cfg(fsfe_pkg::CFG_FLOW_LIMIT, 64'd3);
    no_idle = 1'b1;
    hold_req++;
    push_random(120, 3, 3);
    drain();
    no_idle = 1'b0;
    push_random(200, 4, 4);
    drain();

    // limit of one, zero offset
    write_cfg(fsfe_pkg::CFG_STAMP_OFFSET, 64'd0);
    write_cfg(fsfe_pkg::CFG_FLOW_LIMIT, 64'd1);
    push_random(250, 8, 8);
    drain();

    // widest limit again
    write_cfg(fsfe_pkg::CFG_STAMP_OFFSET, {$urandom, $urandom});
    write_cfg(fsfe_pkg::CFG_FLOW_LIMIT, 64'd255);
    push_random(250, 6, 5);
    drain();

    // fill the flow table with new flows until new ones are dropped
    write_cfg(fsfe_pkg::CFG_FLOW_LIMIT, 64'(fsfe_pkg::LIMIT_RESET));
    need = fsfe_pkg::FLOW_ENTRIES - flow_count.num() + 20;
    repeat (need) begin
      frame_queue.push_back(build_frame(($urandom_range(0, 1) != 0) ? fsfe_pkg::PROTO_TCP :
                                                                      fsfe_pkg::PROTO_UDP,
                                        $urandom, $urandom, 16'($urandom), 16'($urandom),
                                        8'd0));
    end
    drain();

    // known flows keep going in a full table
    push_random(60, 8, 8);
    drain();

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ flow_sampling_feature_extractor.f @@
hw/rtl/fsfe_pkg.sv
hw/rtl/fsfe_in_if.sv
hw/rtl/fsfe_out_if.sv
hw/rtl/fsfe_parse.sv
hw/rtl/fsfe_table.sv
hw/rtl/flow_sampling_feature_extractor.sv
tb/tb_flow_sampling_feature_extractor.sv
